[rtl/core/fpm_pkg.sv]
package fpm_pkg;

  localparam int Q16_ONE = 65536;

  // color_mode codes
  localparam logic [2:0] MODE_BINARY  = 3'd0;
  localparam logic [2:0] MODE_GRAY    = 3'd1;
  localparam logic [2:0] MODE_ICE     = 3'd2;
  localparam logic [2:0] MODE_FIRE    = 3'd3;
  localparam logic [2:0] MODE_VIRIDIS = 3'd4;
  localparam logic [2:0] MODE_PLASMA  = 3'd5;
  localparam logic [2:0] MODE_TEMP    = 3'd6;
  localparam logic [2:0] MODE_DUAL    = 3'd7;

  // register indexes
  localparam logic CFG_COLOR_MODE  = 1'b0;
  localparam logic CFG_GLOW_ENABLE = 1'b1;
  localparam int   CFG_DATA_W      = 3;

  localparam logic [2:0] COLOR_MODE_RST = MODE_ICE;

  // polynomial palettes, Q16, coefficient k multiplies t^k
  localparam int VIR_C [3][5] = '{
    '{17498, 6881, 407962, -914489, 613220},
    '{328, 92013, -99287, 68223, -15204},
    '{21561, 90767, -205980, 214434, -72810}};
  localparam int PLA_C [3][5] = '{
    '{3277, 152764, -268632, 298516, -120324},
    '{1901, -19071, 113246, -77332, 46924},
    '{34537, 96076, -296681, 294322, -128254}};

  // fire palette breakpoints and reciprocals (2^32 / span)
  localparam logic [16:0] FIRE_BP1  = 17'd21627;
  localparam logic [16:0] FIRE_BP2  = 17'd43254;
  localparam logic [14:0] FIRE_D01  = 15'd21627;
  localparam logic [14:0] FIRE_D2   = 15'd22282;
  localparam longint      FIRE_R01L = 64'h1_0000_0000 / 21627;
  localparam longint      FIRE_R2L  = 64'h1_0000_0000 / 22282;
  localparam logic [17:0] FIRE_R01  = 18'(FIRE_R01L);
  localparam logic [17:0] FIRE_R2   = 18'(FIRE_R2L);

  localparam logic [16:0] GLOW_LO = 17'd3277;
  localparam logic [16:0] GLOW_HI = 17'd62259;

  // log2(y/65536) in Q24, elaboration use only
  function automatic longint log2q(input longint unsigned y);
    int p;
    longint unsigned m;
    longint fr;
    p  = 16;
    fr = 0;
    while (p > 0 && ((y >> p) & 64'd1) == 64'd0) p--;
    m = y << (30 - p);
    for (int i = 0; i < 24; i++) begin
      m  = (m * m) >> 30;
      fr = fr << 1;
      if (m >= 64'h8000_0000) begin
        fr = fr | 64'sd1;
        m  = m >> 1;
      end
    end
    return longint'(p - 16) * 64'sd16777216 + fr;
  endfunction

  // smallest Q16 y >= 1 with den*log2(y) >= num*log2(t)
  function automatic logic [16:0] pow_q16(input longint unsigned t, input longint num,
                                          input longint den);
    longint target;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    if (t == 0) return 17'd0;
    target = num * log2q(t);
    lo = 1;
    hi = 65536;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (den * log2q(mid) >= target) hi = mid;
      else lo = mid + 1;
    end
    return 17'(lo);
  endfunction

  // clamp to 0..1 (Q16) and scale to 0..255
  function automatic logic [7:0] to8(input logic signed [31:0] v);
    logic [16:0] c;
    logic [24:0] m;
    if (v < 0) c = 17'd0;
    else if (v > 32'sd65536) c = 17'd65536;
    else c = v[16:0];
    m = {c, 8'b0} - {8'b0, c};
    return m[23:16];
  endfunction

endpackage

[rtl/core/fpm_in_if.sv]
interface fpm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] phase_value;
  logic signed [15:0] temperature_value;

  modport source(output valid, output phase_value, output temperature_value, input ready);
  modport sink(input valid, input phase_value, input temperature_value, output ready);
endinterface

[rtl/core/fpm_out_if.sv]
interface fpm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source(output valid, output red, output green, output blue, input ready);
  modport sink(input valid, input red, input green, input blue, output ready);
endinterface

[rtl/core/field_pseudocolor_mapper_unit.sv]
// Pseudocolor mapper: one phase/temperature pixel in, one RGB pixel out.
// in_s carries phase_value and temperature_value (signed, FRAC_BITS
// fraction bits); out_s carries red, green, blue. Both use valid/ready.
// cfg_we_i/cfg_index_i/cfg_data_i write color_mode (index 0) and
// glow_enable (index 1); write them only while no pixel is in flight.
// A pixel accepted on in_s shows on out_s after the seventh register
// stage. The longest chains, the four multiply steps of the polynomial
// palettes and the fire divide, end in stage 5; stage 6 picks the
// palette, stage 7 adds glow. One pixel per clock unless out_s stalls.
// The pipeline advances as one: when out_s holds a pixel that is not
// taken, every stage holds and in_s.ready drops in the same cycle, so
// nothing is lost or repeated.
// Reset clears all valid bits and loads color_mode = ice blue,
// glow_enable = 0. The power tables are constant ROMs built at
// elaboration, so there is no clearing pass.
module field_pseudocolor_mapper_unit
  import fpm_pkg::*;
#(
  parameter int FRAC_BITS           = 12,
  parameter int POWER_TABLE_ENTRIES = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  fpm_in_if.sink                in_s,
  fpm_out_if.source             out_s
);

  localparam int IW   = $clog2(POWER_TABLE_ENTRIES);
  localparam int NST  = 7;
  localparam int SH   = 16 - FRAC_BITS;
  localparam logic signed [17:0] ONE_S = 18'sd1 <<< FRAC_BITS;
  localparam logic [IW:0] IDX_MAX = (IW+1)'(POWER_TABLE_ENTRIES - 1);
  localparam longint unsigned ROM_DEN  = POWER_TABLE_ENTRIES - 1;
  localparam longint unsigned ROM_HALF = (POWER_TABLE_ENTRIES - 1) / 2;

  typedef logic [16:0] rom_t [POWER_TABLE_ENTRIES];

  typedef struct packed {
    logic [2:0]         mode;
    logic               glow;
    logic               glow_on;
    logic               pos;
    logic [16:0]        t;
    logic [16:0]        tu;
    logic [16:0]        w;
    logic [16:0]        td;
    logic [IW-1:0]      i13;
    logic [IW-1:0]      i06;
    logic [IW-1:0]      i05;
    logic [16:0]        t2;
    logic [16:0]        p13;
    logic [16:0]        p06;
    logic [16:0]        p05;
    logic signed [31:0] acc0;
    logic signed [31:0] acc1;
    logic signed [31:0] acc2;
    logic [1:0]         seg;
    logic [14:0]        num;
    logic [16:0]        fq;
    logic [31:0]        fr;
    logic [16:0]        ice_r;
    logic [16:0]        ice_g;
    logic [16:0]        ice_b;
    logic [16:0]        tmp_g;
    logic [7:0]         tr;
    logic [7:0]         tg;
    logic [7:0]         tb;
    logic [14:0]        g;
    logic [6:0]         gr;
    logic [6:0]         gg;
    logic [6:0]         gb;
    logic [7:0]         r;
    logic [7:0]         gn;
    logic [7:0]         b;
  } pix_t;

  // sample point i is round(i*65536/(N-1)), quotient found bit by bit
  function automatic rom_t build_rom(input longint num, input longint den);
    rom_t rom;
    longint unsigned nv;
    longint unsigned tv;
    longint unsigned tb;
    for (int i = 0; i < POWER_TABLE_ENTRIES; i++) begin
      nv = longint'(i) * 65536 + ROM_HALF;
      tv = 0;
      for (int b = 16; b >= 0; b--) begin
        tb = tv | (64'd1 << b);
        if (tb * ROM_DEN <= nv) tv = tb;
      end
      rom[i] = pow_q16(tv, num, den);
    end
    return rom;
  endfunction

  localparam rom_t ROM13 = build_rom(13, 10);
  localparam rom_t ROM06 = build_rom(3, 5);
  localparam rom_t ROM05 = build_rom(1, 2);

  function automatic logic signed [17:0] clamp_one(input logic signed [15:0] v);
    logic signed [17:0] x;
    x = 18'(v);
    if (x > ONE_S) x = ONE_S;
    if (x < -ONE_S) x = -ONE_S;
    return x;
  endfunction

  // (v+1)/2 in Q16 for clamped v
  function automatic logic [16:0] norm_q16(input logic signed [17:0] v);
    logic [18:0] s;
    s = 19'(v + ONE_S) << SH;
    return s[17:1];
  endfunction

  function automatic logic [IW-1:0] rom_idx(input logic [16:0] v);
    logic [IW+16:0] p;
    logic [IW:0]    q;
    p = (IW+17)'(v) * (IW+17)'(POWER_TABLE_ENTRIES - 1) + (IW+17)'(32768);
    q = p[IW+16:16];
    if (q > IDX_MAX) q = IDX_MAX;
    return q[IW-1:0];
  endfunction

  function automatic logic signed [31:0] coef(input logic [2:0] mode, input int ch,
                                              input int k);
    return (mode == MODE_PLASMA) ? 32'(PLA_C[ch][k]) : 32'(VIR_C[ch][k]);
  endfunction

  function automatic logic signed [31:0] horner(input logic signed [31:0] c,
                                                input logic signed [31:0] acc,
                                                input logic [16:0] t);
    logic signed [49:0] p;
    p = acc * $signed({1'b0, t});
    return c + p[47:16];
  endfunction

  function automatic logic [14:0] fire_div(input logic [1:0] seg);
    return (seg == 2'd2) ? FIRE_D2 : FIRE_D01;
  endfunction

  function automatic logic signed [31:0] sx(input logic [16:0] v);
    return $signed({15'b0, v});
  endfunction

  function automatic logic [7:0] dim8(input logic [7:0] x, input logic [15:0] k);
    logic [23:0] p;
    p = 24'(x) * 24'(k);
    return p[23:16];
  endfunction

  function automatic logic [6:0] gain(input logic [14:0] g, input logic [7:0] k);
    logic [22:0] p;
    p = 23'(g) * 23'(k);
    return p[22:16];
  endfunction

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [6:0] g);
    logic [8:0] s;
    s = {1'b0, a} + {2'b0, g};
    return s[8] ? 8'd255 : s[7:0];
  endfunction

  logic [2:0] color_mode_q;
  logic       glow_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q  <= COLOR_MODE_RST;
      glow_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_COLOR_MODE:  color_mode_q  <= cfg_data_i;
        CFG_GLOW_ENABLE: glow_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  pix_t           st_q [NST];
  pix_t           st_d [NST];
  logic [NST-1:0] vld_q;
  logic [NST-1:0] vld_d;
  logic           en;

  assign en         = !vld_q[NST-1] || out_s.ready;
  assign in_s.ready = en;
  assign vld_d      = {vld_q[NST-2:0], in_s.valid};

  always_comb begin
    logic signed [17:0] phc;
    logic signed [17:0] a;
    logic [17:0]        wa;
    logic [33:0]        tt;
    logic signed [18:0] dd;
    logic [32:0]        fp;
    logic [32:0]        mp;
    logic [31:0]        qd;
    logic [7:0]         br;
    logic [7:0]         bg;
    logic [7:0]         bb;

    // stage 1: clamp and normalize
    st_d[0]      = st_q[0];
    phc          = clamp_one(in_s.phase_value);
    a            = (phc < 0) ? -phc : phc;
    wa           = 18'(ONE_S - a) << SH;
    st_d[0].mode = color_mode_q;
    st_d[0].glow = glow_enable_q;
    st_d[0].pos  = (phc > 0);
    st_d[0].t    = norm_q16(phc);
    st_d[0].tu   = norm_q16(clamp_one(in_s.temperature_value));
    st_d[0].w    = wa[16:0];
    st_d[0].acc0 = coef(color_mode_q, 0, 4);
    st_d[0].acc1 = coef(color_mode_q, 1, 4);
    st_d[0].acc2 = coef(color_mode_q, 2, 4);

    // stage 2: table indexes, t squared, fire segment, first Horner step
    st_d[1]     = st_q[0];
    st_d[1].i13 = rom_idx(st_q[0].t);
    st_d[1].i06 = rom_idx(st_q[0].t);
    st_d[1].i05 = rom_idx(st_q[0].w);
    tt          = 34'(st_q[0].t) * 34'(st_q[0].t);
    st_d[1].t2  = tt[32:16];
    if (st_q[0].t < FIRE_BP1) begin
      st_d[1].seg = 2'd0;
      st_d[1].num = st_q[0].t[14:0];
    end else if (st_q[0].t < FIRE_BP2) begin
      st_d[1].seg = 2'd1;
      st_d[1].num = 15'(st_q[0].t - FIRE_BP1);
    end else begin
      st_d[1].seg = 2'd2;
      st_d[1].num = 15'(st_q[0].t - FIRE_BP2);
    end
    dd              = $signed({1'b0, st_q[0].tu, 1'b0}) - 19'sd65536;
    st_d[1].td      = (dd < 0) ? 17'(-dd) : 17'(dd);
    st_d[1].glow_on = st_q[0].glow && st_q[0].w > GLOW_LO && st_q[0].w < GLOW_HI &&
                      st_q[0].mode != MODE_BINARY && st_q[0].mode != MODE_TEMP;
    st_d[1].acc0 = horner(coef(st_q[0].mode, 0, 3), st_q[0].acc0, st_q[0].t);
    st_d[1].acc1 = horner(coef(st_q[0].mode, 1, 3), st_q[0].acc1, st_q[0].t);
    st_d[1].acc2 = horner(coef(st_q[0].mode, 2, 3), st_q[0].acc2, st_q[0].t);

    // stage 3: table reads, fire quotient estimate
    st_d[2]       = st_q[1];
    st_d[2].p13   = ROM13[st_q[1].i13];
    st_d[2].p06   = ROM06[st_q[1].i06];
    st_d[2].p05   = ROM05[st_q[1].i05];
    mp            = 33'(st_q[1].t2) * 33'd55706;
    st_d[2].ice_r = 17'd3277 + mp[32:16];
    fp            = 33'(st_q[1].num) * 33'((st_q[1].seg == 2'd2) ? FIRE_R2 : FIRE_R01);
    st_d[2].fq    = fp[32:16];
    mp            = 33'(17'd65536 - st_q[1].td) * 33'd26214;
    st_d[2].tmp_g = 17'd19661 + mp[32:16];
    st_d[2].acc0  = horner(coef(st_q[1].mode, 0, 2), st_q[1].acc0, st_q[1].t);
    st_d[2].acc1  = horner(coef(st_q[1].mode, 1, 2), st_q[1].acc1, st_q[1].t);
    st_d[2].acc2  = horner(coef(st_q[1].mode, 2, 2), st_q[1].acc2, st_q[1].t);

    // stage 4: ice green/blue, fire remainder, glow amplitude, temperature
    st_d[3]       = st_q[2];
    mp            = 33'(st_q[2].p13) * 33'd52429;
    st_d[3].ice_g = 17'd6554 + mp[32:16];
    mp            = 33'(st_q[2].p06) * 33'd49152;
    st_d[3].ice_b = 17'd13107 + mp[32:16];
    qd            = 32'(st_q[2].fq) * 32'(fire_div(st_q[2].seg));
    st_d[3].fr    = {1'b0, st_q[2].num, 16'b0} - qd;
    mp            = 33'(st_q[2].p05) * 33'd22938;
    st_d[3].g     = mp[30:16];
    st_d[3].tr    = to8(sx(st_q[2].tu));
    st_d[3].tg    = to8(sx(st_q[2].tmp_g));
    st_d[3].tb    = to8(sx(17'd65536 - st_q[2].tu));
    st_d[3].acc0  = horner(coef(st_q[2].mode, 0, 1), st_q[2].acc0, st_q[2].t);
    st_d[3].acc1  = horner(coef(st_q[2].mode, 1, 1), st_q[2].acc1, st_q[2].t);
    st_d[3].acc2  = horner(coef(st_q[2].mode, 2, 1), st_q[2].acc2, st_q[2].t);

    // stage 5: last Horner step, quotient fixup, glow gains, dual dimming
    st_d[4]      = st_q[3];
    st_d[4].acc0 = horner(coef(st_q[3].mode, 0, 0), st_q[3].acc0, st_q[3].t);
    st_d[4].acc1 = horner(coef(st_q[3].mode, 1, 0), st_q[3].acc1, st_q[3].t);
    st_d[4].acc2 = horner(coef(st_q[3].mode, 2, 0), st_q[3].acc2, st_q[3].t);
    st_d[4].fq   = st_q[3].fq +
                   17'(st_q[3].fr >= 32'(fire_div(st_q[3].seg)));
    st_d[4].gr   = gain(st_q[3].g, 8'd200);
    st_d[4].gg   = gain(st_q[3].g, 8'd180);
    st_d[4].gb   = gain(st_q[3].g, 8'd100);
    if (st_q[3].mode == MODE_DUAL) begin
      st_d[4].tr = dim8(st_q[3].tr, 16'd39322);
      st_d[4].tg = dim8(st_q[3].tg, 16'd39322);
      st_d[4].tb = dim8(st_q[3].tb, 16'd45875);
    end

    // stage 6: palette select
    st_d[5] = st_q[4];
    br = 8'd0;
    bg = 8'd0;
    bb = 8'd0;
    case (st_q[4].mode)
      MODE_BINARY: begin
        br = st_q[4].pos ? 8'd255 : 8'd0;
        bg = br;
        bb = br;
      end
      MODE_GRAY: begin
        br = to8(sx(st_q[4].t));
        bg = br;
        bb = br;
      end
      MODE_ICE: begin
        br = to8(sx(st_q[4].ice_r));
        bg = to8(sx(st_q[4].ice_g));
        bb = to8(sx(st_q[4].ice_b));
      end
      MODE_FIRE: begin
        case (st_q[4].seg)
          2'd0: br = to8(sx(st_q[4].fq));
          2'd1: begin
            br = 8'd255;
            bg = to8(sx(st_q[4].fq));
          end
          default: begin
            br = 8'd255;
            bg = 8'd255;
            bb = to8(sx(st_q[4].fq));
          end
        endcase
      end
      MODE_VIRIDIS, MODE_PLASMA: begin
        br = to8(st_q[4].acc0);
        bg = to8(st_q[4].acc1);
        bb = to8(st_q[4].acc2);
      end
      MODE_TEMP: begin
        br = st_q[4].tr;
        bg = st_q[4].tg;
        bb = st_q[4].tb;
      end
      default: begin
        if (st_q[4].pos) begin
          br = to8(sx(st_q[4].ice_r));
          bg = to8(sx(st_q[4].ice_g));
          bb = to8(sx(st_q[4].ice_b));
        end else begin
          br = st_q[4].tr;
          bg = st_q[4].tg;
          bb = st_q[4].tb;
        end
      end
    endcase
    st_d[5].r  = br;
    st_d[5].gn = bg;
    st_d[5].b  = bb;

    // stage 7: interface glow, output register
    st_d[6] = st_q[5];
    if (st_q[5].glow_on) begin
      st_d[6].r  = sat_add(st_q[5].r, st_q[5].gr);
      st_d[6].gn = sat_add(st_q[5].gn, st_q[5].gg);
      st_d[6].b  = sat_add(st_q[5].b, st_q[5].gb);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q <= st_d;
    end
  end

  assign out_s.valid = vld_q[NST-1];
  assign out_s.red   = st_q[NST-1].r;
  assign out_s.green = st_q[NST-1].gn;
  assign out_s.blue  = st_q[NST-1].b;

endmodule

[rtl/core/fpm_checker.sv]
module fpm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue
);

  // hold a stalled item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(red) && $stable(green) && $stable(blue))
    else $error("output item changed while stalled");

  // a stall at the output must freeze the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline is stalled");

  // the pipeline never blocks while the output is being drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready |-> in_ready)
    else $error("input blocked while output is ready");

endmodule

bind field_pseudocolor_mapper_unit fpm_checker u_fpm_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_ready (in_s.ready),
  .out_valid(out_s.valid),
  .out_ready(out_s.ready),
  .red      (out_s.red),
  .green    (out_s.green),
  .blue     (out_s.blue)
);

[verif/fpm_colormap_checker.sv]
module fpm_colormap_checker
  import fpm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  fpm_in_if                     pix_in,
  fpm_out_if                    pix_out,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam longint ONE_Q = 4096;
  localparam int     ROM_N = 256;

  localparam longint VIR_K [3][5] = '{
    '{17498, 6881, 407962, -914489, 613220},
    '{328, 92013, -99287, 68223, -15204},
    '{21561, 90767, -205980, 214434, -72810}};
  localparam longint PLA_K [3][5] = '{
    '{3277, 152764, -268632, 298516, -120324},
    '{1901, -19071, 113246, -77332, 46924},
    '{34537, 96076, -296681, 294322, -128254}};

  longint     pow13_rom [ROM_N];
  longint     pow06_rom [ROM_N];
  longint     sqrt_rom  [ROM_N];
  logic [2:0] mode_q;
  logic       glow_q;
  rgb_t       want_q [$];

  // log2 of y/65536 with 24 fraction bits, squaring method
  function automatic longint fix_log2(longint unsigned y);
    int p;
    longint unsigned m;
    longint f;
    p = 16;
    f = 0;
    while (p > 0 && y[p] == 1'b0) p--;
    m = y << (30 - p);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      f = f << 1;
      if (m >= 64'h8000_0000) begin
        f = f + 1;
        m = m >> 1;
      end
    end
    return longint'(p - 16) * 16777216 + f;
  endfunction

  function automatic longint fix_pow(longint unsigned t, longint num, longint den);
    longint goal;
    longint unsigned lo, hi, mid;
    if (t == 0) return 0;
    goal = num * fix_log2(t);
    lo = 1;
    hi = 65536;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (den * fix_log2(mid) >= goal) hi = mid;
      else lo = mid + 1;
    end
    return longint'(lo);
  endfunction

  function automatic longint clamp_q(longint v);
    return v < 0 ? 0 : (v > 65536 ? 65536 : v);
  endfunction

  function automatic int rom_index(longint v);
    longint idx;
    idx = (clamp_q(v) * (ROM_N - 1) + 32768) >>> 16;
    return idx > ROM_N - 1 ? ROM_N - 1 : int'(idx);
  endfunction

  function automatic logic [7:0] scale_byte(longint v);
    return 8'((clamp_q(v) * 255) >>> 16);
  endfunction

  function automatic longint unit_q16(logic signed [15:0] v);
    longint x;
    x = v;
    if (x > ONE_Q) x = ONE_Q;
    if (x < -ONE_Q) x = -ONE_Q;
    return (x + ONE_Q) <<< 3;
  endfunction

  function automatic logic [7:0] poly_byte(longint t, int ch, logic plasma);
    longint acc;
    acc = plasma ? PLA_K[ch][4] : VIR_K[ch][4];
    for (int k = 3; k >= 0; k--)
      acc = (plasma ? PLA_K[ch][k] : VIR_K[ch][k]) + ((acc * t) >>> 16);
    return scale_byte(acc);
  endfunction

  function automatic rgb_t ice_color(longint t);
    rgb_t c;
    c.red   = scale_byte(3277 + ((55706 * ((t * t) >>> 16)) >>> 16));
    c.green = scale_byte(6554 + ((52429 * pow13_rom[rom_index(t)]) >>> 16));
    c.blue  = scale_byte(13107 + ((49152 * pow06_rom[rom_index(t)]) >>> 16));
    return c;
  endfunction

  function automatic rgb_t heat_color(longint t);
    rgb_t c;
    longint d;
    d = 2 * t - 65536;
    if (d < 0) d = -d;
    c.red   = scale_byte(t);
    c.green = scale_byte(19661 + ((26214 * (65536 - d)) >>> 16));
    c.blue  = scale_byte(65536 - t);
    return c;
  endfunction

  function automatic rgb_t map_pixel(logic signed [15:0] ph, logic signed [15:0] tp);
    rgb_t c;
    longint phi, t, w, g;
    longint gain [3];
    longint sum [3];
    phi = ph;
    if (phi > ONE_Q) phi = ONE_Q;
    if (phi < -ONE_Q) phi = -ONE_Q;
    t = unit_q16(ph);
    gain = '{200, 180, 100};
    case (mode_q)
      MODE_BINARY: begin
        c = phi > 0 ? 24'hFF_FFFF : 24'h0;
        return c;
      end
      MODE_GRAY: c = {3{scale_byte(t)}};
      MODE_ICE: c = ice_color(t);
      MODE_FIRE: begin
        if (t < 21627) begin
          c = '0;
          c.red = scale_byte(t * 65536 / 21627);
        end else if (t < 43254) begin
          c = '0;
          c.red = 8'hFF;
          c.green = scale_byte((t - 21627) * 65536 / 21627);
        end else begin
          c.red = 8'hFF;
          c.green = 8'hFF;
          c.blue = scale_byte((t - 43254) * 65536 / 22282);
        end
      end
      MODE_VIRIDIS, MODE_PLASMA: begin
        c.red   = poly_byte(t, 0, mode_q == MODE_PLASMA);
        c.green = poly_byte(t, 1, mode_q == MODE_PLASMA);
        c.blue  = poly_byte(t, 2, mode_q == MODE_PLASMA);
      end
      MODE_TEMP: return heat_color(unit_q16(tp));
      default: begin
        if (phi > 0) c = ice_color(t);
        else begin
          // dim the heat palette on the negative side
          c = heat_color(unit_q16(tp));
          c.red   = 8'((longint'(c.red) * 39322) >>> 16);
          c.green = 8'((longint'(c.green) * 39322) >>> 16);
          c.blue  = 8'((longint'(c.blue) * 45875) >>> 16);
        end
      end
    endcase
    if (glow_q) begin
      w = (ONE_Q - (phi < 0 ? -phi : phi)) <<< 4;
      if (w > 3277 && w < 62259) begin
        g = (sqrt_rom[rom_index(w)] * 22938) >>> 16;
        sum[0] = c.red + ((g * gain[0]) >>> 16);
        sum[1] = c.green + ((g * gain[1]) >>> 16);
        sum[2] = c.blue + ((g * gain[2]) >>> 16);
        c.red   = sum[0] > 255 ? 8'hFF : 8'(sum[0]);
        c.green = sum[1] > 255 ? 8'hFF : 8'(sum[1]);
        c.blue  = sum[2] > 255 ? 8'hFF : 8'(sum[2]);
      end
    end
    return c;
  endfunction

  initial begin
    longint tv;
    for (int i = 0; i < ROM_N; i++) begin
      tv = (longint'(i) * 65536 + (ROM_N - 1) / 2) / (ROM_N - 1);
      pow13_rom[i] = fix_pow(tv, 13, 10);
      pow06_rom[i] = fix_pow(tv, 3, 5);
      sqrt_rom[i]  = fix_pow(tv, 1, 2);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    rgb_t got, want;
    if (!rst_ni) begin
      mode_q <= COLOR_MODE_RST;
      glow_q <= 1'b0;
      want_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_COLOR_MODE) mode_q <= cfg_data_i[2:0];
        else glow_q <= cfg_data_i[0];
      end
      if (pix_in.valid && pix_in.ready)
        want_q.push_back(map_pixel(pix_in.phase_value, pix_in.temperature_value));
      if (pix_out.valid && pix_out.ready) begin
        got = {pix_out.red, pix_out.green, pix_out.blue};
        if (want_q.size() == 0) begin
          $display("%0t: unexpected pixel, actual %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = want_q.pop_front();
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            $display("%0t: pixel mismatch, expected r%0d g%0d b%0d actual r%0d g%0d b%0d",
                     $time, want.red, want.green, want.blue, got.red, got.green, got.blue);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= want_q.size();
    end
  end

endmodule

[verif/tb.sv]
module tb
  import fpm_pkg::*;
();

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic                  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    fail_count;
  int                    pending;
  bit                    hold_req;

  fpm_in_if  pix_in ();
  fpm_out_if pix_out ();

  field_pseudocolor_mapper_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_s       (pix_in),
    .out_s      (pix_out)
  );

  fpm_colormap_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_in      (pix_in),
    .pix_out     (pix_out),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // clamp edges, glow window edges, fire breakpoint
  localparam logic signed [15:0] EDGE_VALS [16] = '{
    -16'sd32768, 16'sd32767, -16'sd4097, -16'sd4096, -16'sd4095, -16'sd1, 16'sd0, 16'sd1,
    16'sd4095, 16'sd4096, 16'sd4097, 16'sd3891, -16'sd3892, 16'sd204, -16'sd205, -16'sd1393};

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [15:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 16'($urandom);
    if (r < 4) return EDGE_VALS[$urandom_range(0, 15)];
    return 16'($urandom_range(0, 8400) - 4200);
  endfunction

  // leave the enable high; the caller drops it after the last write
  task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // offer one item; hold it until accepted
  task automatic push_pixel(logic [15:0] ph, logic [15:0] tp);
    pix_in.valid             <= 1'b1;
    pix_in.phase_value       <= ph;
    pix_in.temperature_value <= tp;
    do @(posedge clk_i); while (!pix_in.ready);
  endtask

  task automatic send_burst(int n);
    int left;
    left = n;
    while (left > 0) begin
      push_pixel(pick_value(), pick_value());
      left--;
      if ($urandom_range(0, 5) == 0 || left == 0) begin
        pix_in.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  // receiver: stall pattern picked anew at random, long hold-off on request
  initial begin
    int style;
    pix_out.ready = 1'b0;
    style = 0;
    @(posedge rst_ni);
    forever begin
      style = $urandom_range(0, 2);
      for (int c = 0; c < 64; c++) begin
        @(posedge clk_i);
        if (hold_req) begin
          pix_out.ready <= 1'b0;
          repeat (60) @(posedge clk_i);
          hold_req = 0;
        end else case (style)
          0: pix_out.ready <= 1'b1;
          1: pix_out.ready <= 1'($urandom);
          default: pix_out.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_COLOR_MODE;
    cfg_data_i = '0;
    pix_in.valid = 1'b0;
    pix_in.phase_value = '0;
    pix_in.temperature_value = '0;
    hold_req = 0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset palette on edge values
    for (int i = 0; i < 16; i++) push_pixel(EDGE_VALS[i], EDGE_VALS[15 - i]);
    pix_in.valid <= 1'b0;
    drain();

    for (int ph = 0; ph < 18; ph++) begin
      if (ph < 16) begin
        write_reg(CFG_COLOR_MODE, 3'(ph % 8));
        write_reg(CFG_GLOW_ENABLE, 3'(ph / 8));
      end else begin
        write_reg(CFG_COLOR_MODE, 3'($urandom_range(0, 7)));
        write_reg(CFG_GLOW_ENABLE, 3'($urandom_range(0, 1)));
      end
      cfg_we_i <= 1'b0;
      if (ph == 5) hold_req = 1;
      for (int e = 0; e < 16; e += 4) push_pixel(EDGE_VALS[e + 1], EDGE_VALS[e]);
      send_burst($urandom_range(8, 30));
      pix_in.valid <= 1'b0;
      drain();
    end

    drain();
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
